[hdl/grm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the gain ramp mixer: parameter defaults, register
// indexes, mode codes and the fixed extension of the gain accumulator.
// No dependencies.
package grm_pkg;

  // parameter defaults
  localparam int SampleBitsDef   = 24;
  localparam int GainFracBitsDef = 20;
  localparam int RunCountBitsDef = 16;

  // integer bits of a gain (Q4.x)
  localparam int GainIntBits = 4;
  // extra fraction bits kept below the gain in the accumulator
  localparam int AccExtBits  = 24;
  // ramp length after reset
  localparam int RampLenReset = 256;

  // configuration register indexes
  localparam int CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] REG_MODE        = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_START_GAIN  = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_END_GAIN    = 2'd2;
  localparam logic [CfgIdxBits-1:0] REG_RAMP_LENGTH = 2'd3;

  // mixing modes; the unused code behaves as scale
  localparam int ModeBits = 2;
  localparam logic [ModeBits-1:0] MODE_SCALE = 2'd0;
  localparam logic [ModeBits-1:0] MODE_ADD   = 2'd1;
  localparam logic [ModeBits-1:0] MODE_COPY  = 2'd2;

  // step divider sequencer
  typedef enum logic [3:0] {
    DIV_IDLE = 4'b0001,
    DIV_LOAD = 4'b0010,
    DIV_RUN  = 4'b0100,
    DIV_SIGN = 4'b1000
  } div_state_t;

endpackage

[hdl/gain_ramp_mixer.sv]
`timescale 1ns / 1ps
// Gain ramp mixer top level: stream datapath, ramp state and step divider.
// Depends on grm_pkg.
//
//  channel   dir  fields (lowest bit up)                     handshake
//  s_axis    in   tdata: dest_sample, source_sample          tvalid/tready
//  m_axis    out  tdata: result_sample; tlast: last_of_run;  tvalid/tready
//                 tuser: clipped
//  cfg       in   cfg_index, cfg_data                        cfg_we, no wait
//
// One sample per cycle while the divider is idle and the output is not stalled; a
// result goes through the input register, then one multiply, round, add and
// saturate into the result register. Every register write restarts the run and
// reruns the restoring step divider, one quotient bit per cycle, and the input
// stalls until the divide is done. After reset the step is zero and no divide
// runs. A stalled output holds the pipeline.
module gain_ramp_mixer #(
  parameter int SAMPLE_BITS    = grm_pkg::SampleBitsDef,
  parameter int GAIN_FRAC_BITS = grm_pkg::GainFracBitsDef,
  parameter int RUN_COUNT_BITS = grm_pkg::RunCountBitsDef,
  localparam int GAIN_BITS = GAIN_FRAC_BITS + grm_pkg::GainIntBits,
  localparam int CFG_W     = (GAIN_BITS > RUN_COUNT_BITS) ? GAIN_BITS : RUN_COUNT_BITS,
  localparam int IN_W      = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W     = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,  // dest_sample, source_sample
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_W-1:0]                m_axis_tdata,  // result_sample
  output logic                            m_axis_tlast,  // last_of_run
  output logic                            m_axis_tuser,  // clipped
  // configuration writes
  input  logic                            cfg_we,
  input  logic [grm_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                cfg_data
);
  import grm_pkg::*;

  localparam int ACC_W  = GAIN_BITS + AccExtBits;
  localparam int NUM_W  = GAIN_BITS + AccExtBits;
  localparam int STEP_W = NUM_W + 1;
  localparam int CNT_W  = $clog2(NUM_W);
  localparam int PROD_W = GAIN_BITS + SAMPLE_BITS;
  localparam int SUM_W  = PROD_W + 2 - GAIN_FRAC_BITS;

  // configuration registers
  logic [ModeBits-1:0]       mode;
  logic [GAIN_BITS-1:0]      start_gain;
  logic [GAIN_BITS-1:0]      end_gain;
  logic [RUN_COUNT_BITS-1:0] ramp_length;
  logic [RUN_COUNT_BITS-1:0] len_eff;

  // ramp state
  logic signed [ACC_W-1:0]   gain_accumulator;
  logic signed [STEP_W-1:0]  gain_step;
  logic [RUN_COUNT_BITS-1:0] run_position;

  // divider
  div_state_t                div_state;
  logic [NUM_W-1:0]          div_num;
  logic [RUN_COUNT_BITS-1:0] div_rem;
  logic [CNT_W-1:0]          div_cnt;
  logic                      div_neg;
  logic signed [GAIN_BITS:0] gain_diff;
  logic [GAIN_BITS:0]        diff_mag;
  logic [RUN_COUNT_BITS:0]   div_trial;
  logic                      div_fit;

  // pipeline
  logic                          in_xfer;
  logic                          out_free;
  logic                          s1_adv;
  logic                          at_last;
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_dest;
  logic signed [SAMPLE_BITS-1:0] s1_src;
  logic signed [GAIN_BITS-1:0]   s1_gain;
  logic [ModeBits-1:0]           s1_mode;
  logic                          s1_last;
  logic                          m_valid;
  logic [SAMPLE_BITS-1:0]        m_result;
  logic                          m_last;
  logic                          m_clip;

  // datapath between the registers
  logic signed [SAMPLE_BITS-1:0] operand;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W:0]        prod_rnd;
  logic signed [SUM_W-1:0]       scaled;
  logic signed [SUM_W-1:0]       sum;
  logic                          sat;
  logic [SAMPLE_BITS-1:0]        result_sat;

  // zero length runs as one
  assign len_eff = (ramp_length == '0) ? RUN_COUNT_BITS'(1) : ramp_length;

  // handshake
  assign out_free      = !m_valid || m_axis_tready;
  assign s1_adv        = s1_valid && out_free;
  assign s_axis_tready = (div_state == DIV_IDLE) && (!s1_valid || out_free);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign at_last       = ({1'b0, run_position} + 1'b1) >= {1'b0, len_eff};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_SCALE;
      start_gain  <= GAIN_BITS'(1) << GAIN_FRAC_BITS;
      end_gain    <= GAIN_BITS'(1) << GAIN_FRAC_BITS;
      ramp_length <= RUN_COUNT_BITS'(RampLenReset);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:        mode        <= cfg_data[ModeBits-1:0];
        REG_START_GAIN:  start_gain  <= cfg_data[GAIN_BITS-1:0];
        REG_END_GAIN:    end_gain    <= cfg_data[GAIN_BITS-1:0];
        REG_RAMP_LENGTH: ramp_length <= cfg_data[RUN_COUNT_BITS-1:0];
      endcase
    end
  end

  // divider operands and one restoring step
  assign gain_diff = $signed({end_gain[GAIN_BITS-1], end_gain})
                   - $signed({start_gain[GAIN_BITS-1], start_gain});
  assign diff_mag  = gain_diff[GAIN_BITS] ? (GAIN_BITS+1)'(-gain_diff)
                                          : (GAIN_BITS+1)'(gain_diff);
  assign div_trial = {div_rem, div_num[NUM_W-1]};
  assign div_fit   = div_trial >= {1'b0, len_eff};

  // step divider sequencer and ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      div_state        <= DIV_IDLE;
      gain_step        <= '0;
      gain_accumulator <= {GAIN_BITS'(1) << GAIN_FRAC_BITS, AccExtBits'(0)};
      run_position     <= '0;
    end else if (cfg_we) begin
      div_state <= DIV_LOAD;
    end else begin
      unique case (div_state)
        DIV_IDLE: begin
          // advance the ramp on every input transfer
          if (in_xfer) begin
            if (at_last) begin
              gain_accumulator <= {start_gain, AccExtBits'(0)};
              run_position     <= '0;
            end else begin
              gain_accumulator <= gain_accumulator + gain_step[ACC_W-1:0];
              run_position     <= run_position + 1'b1;
            end
          end
        end
        DIV_LOAD: begin
          // restart the run and load the step dividend
          gain_accumulator <= {start_gain, AccExtBits'(0)};
          run_position     <= '0;
          div_num          <= {diff_mag[GAIN_BITS-1:0], AccExtBits'(0)};
          div_neg          <= gain_diff[GAIN_BITS];
          div_rem          <= '0;
          div_cnt          <= '0;
          div_state        <= DIV_RUN;
        end
        DIV_RUN: begin
          // one quotient bit per cycle, shifted in behind the dividend
          div_rem <= div_fit ? RUN_COUNT_BITS'(div_trial - {1'b0, len_eff})
                             : div_trial[RUN_COUNT_BITS-1:0];
          div_num <= {div_num[NUM_W-2:0], div_fit};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_W'(NUM_W - 1)) begin
            div_state <= DIV_SIGN;
          end
        end
        DIV_SIGN: begin
          // truncate toward zero: negate the magnitude quotient
          gain_step <= div_neg ? -$signed({1'b0, div_num}) : $signed({1'b0, div_num});
          div_state <= DIV_IDLE;
        end
        default: div_state <= DIV_IDLE;
      endcase
    end
  end

  // input register: sample pair with the gain of its position
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_dest <= s_axis_tdata[SAMPLE_BITS-1:0];
      s1_src  <= s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      s1_gain <= gain_accumulator[ACC_W-1:AccExtBits];
      s1_mode <= mode;
      s1_last <= at_last;
    end
  end

  // multiply, round half up, mix and saturate
  assign operand  = (s1_mode == MODE_ADD || s1_mode == MODE_COPY) ? s1_src : s1_dest;
  assign prod     = s1_gain * operand;
  assign prod_rnd = (PROD_W+1)'(prod) + ((PROD_W+1)'(1) << (GAIN_FRAC_BITS - 1));
  assign scaled   = SUM_W'($signed(prod_rnd[PROD_W:GAIN_FRAC_BITS]));
  assign sum      = (s1_mode == MODE_ADD) ? scaled + SUM_W'(s1_dest) : scaled;
  assign sat      = (sum[SUM_W-1:SAMPLE_BITS-1] != '0)
                 && (sum[SUM_W-1:SAMPLE_BITS-1] != '1);
  assign result_sat = !sat ? sum[SAMPLE_BITS-1:0]
                    : sum[SUM_W-1] ? {1'b1, (SAMPLE_BITS-1)'(0)}
                                   : {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (s1_adv) begin
      m_valid <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_result <= result_sat;
      m_last   <= s1_last;
      m_clip   <= sat;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = OUT_W'(m_result);
  assign m_axis_tlast  = m_last;
  assign m_axis_tuser  = m_clip;

  // a run never walks past its length while samples flow
  a_pos_in_run: assert property (@(posedge clk) disable iff (rst)
    (div_state == DIV_IDLE) |-> ({1'b0, run_position} < {1'b0, len_eff}))
    else $error("run position beyond ramp length");

  // the last sample of a run restarts the count
  a_run_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && at_last && !cfg_we) |=> (run_position == '0))
    else $error("run position not cleared after last sample");

  // a clipped result sits on a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_clip) |->
      (m_result == {1'b1, (SAMPLE_BITS-1)'(0)} ||
       m_result == {1'b0, {(SAMPLE_BITS-1){1'b1}}}))
    else $error("clipped result not at a limit");

  // no sample is taken while the step is being divided
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (div_state == DIV_LOAD || div_state == DIV_RUN || div_state == DIV_SIGN)
      |-> !in_xfer)
    else $error("input transfer during step divide");

endmodule

[tb/sv/gain_ramp_mixer_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for gain_ramp_mixer: streams sample pairs under several ramp
// settings and idle patterns and checks every result against a local ramp predictor.
// Depends on grm_pkg and the gain_ramp_mixer RTL.
module gain_ramp_mixer_test;
  import grm_pkg::*;

  localparam int SampleBits = SampleBitsDef;
  localparam int GainFrac   = GainFracBitsDef;
  localparam int GainBits   = GainFrac + GainIntBits;
  localparam int RunBits    = RunCountBitsDef;
  localparam int CfgBits    = (GainBits > RunBits) ? GainBits : RunBits;
  localparam int InBits     = ((2 * SampleBits + 7) / 8) * 8;
  localparam int OutBits    = ((SampleBits + 7) / 8) * 8;

  // the spare mode code, expected to act as scale
  localparam logic [ModeBits-1:0] MODE_SPARE = 2'd3;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [GainBits-1:0]   gain_t;

  localparam sample_t SampleMax = {1'b0, {(SampleBits - 1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleBits - 1){1'b0}}};
  localparam gain_t   GainMax   = {1'b0, {(GainBits - 1){1'b1}}};
  localparam gain_t   GainMin   = {1'b1, {(GainBits - 1){1'b0}}};
  localparam gain_t   GainOne   = GainBits'(1 << GainFrac);

  // one input transfer; dest sits in the low bits
  typedef struct packed {
    sample_t src;
    sample_t dest;
  } sample_pair_t;

  typedef struct {
    sample_t sample;
    logic    last;
    logic    clip;
  } mix_result_t;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InBits-1:0]  s_axis_tdata  = '0;  // dest_sample, source_sample
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutBits-1:0] m_axis_tdata;        // result_sample
  logic               m_axis_tlast;        // last_of_run
  logic               m_axis_tuser;        // clipped
  logic               cfg_we        = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index  = REG_MODE;
  logic [CfgBits-1:0] cfg_data      = '0;

  gain_ramp_mixer u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // pairs waiting to be sent, results waiting to come back
  sample_pair_t pending[$];
  mix_result_t  awaited[$];
  int           errors    = 0;
  int           idle_pct  = 0;
  int           stall_pct = 0;
  bit           in_fire   = 1'b0;

  // predictor copy of registers and ramp state
  logic [ModeBits-1:0] mix_mode;
  gain_t               ramp_start;
  gain_t               ramp_end;
  logic [RunBits-1:0]  ramp_len;
  longint              gain_acc;
  longint              gain_inc;
  int unsigned         run_pos;

  function automatic int unsigned run_samples();
    return (ramp_len == 0) ? 1 : int'(ramp_len);
  endfunction

  // recompute the step and reload the accumulator at the start of a run
  function automatic void restart_ramp();
    longint span;
    span     = (longint'(ramp_end) - longint'(ramp_start)) <<< AccExtBits;
    gain_inc = span / longint'(run_samples());
    gain_acc = longint'(ramp_start) <<< AccExtBits;
    run_pos  = 0;
  endfunction

  // gain one pair, saturate and advance the ramp
  function automatic mix_result_t mix_predict(sample_pair_t p);
    mix_result_t r;
    longint      gain;
    longint      operand;
    longint      mixed;
    gain    = gain_acc >>> AccExtBits;
    operand = (mix_mode == MODE_ADD || mix_mode == MODE_COPY) ?
              longint'($signed(p.src)) : longint'($signed(p.dest));
    mixed   = (gain * operand + (longint'(1) <<< (GainFrac - 1))) >>> GainFrac;
    if (mix_mode == MODE_ADD) mixed += longint'($signed(p.dest));
    r.clip = 1'b0;
    if (mixed > longint'(SampleMax)) begin
      mixed  = longint'(SampleMax);
      r.clip = 1'b1;
    end
    if (mixed < longint'(SampleMin)) begin
      mixed  = longint'(SampleMin);
      r.clip = 1'b1;
    end
    r.sample = sample_t'(mixed);
    r.last   = (run_pos + 1 >= run_samples());
    if (r.last) begin
      gain_acc = longint'(ramp_start) <<< AccExtBits;
      run_pos  = 0;
    end else begin
      gain_acc += gain_inc;
      run_pos++;
    end
    return r;
  endfunction

  // check result transfers, then predict on input transfers
  always @(posedge clk) begin : check_p
    mix_result_t want;
    in_fire = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited.size() == 0) begin
          $error("unexpected result transfer: result_sample %0d",
                 $signed(m_axis_tdata[SampleBits-1:0]));
          errors++;
        end else begin
          want = awaited.pop_front();
          if ($signed(m_axis_tdata[SampleBits-1:0]) !== want.sample) begin
            $error("result_sample: expected %0d, got %0d", want.sample,
                   $signed(m_axis_tdata[SampleBits-1:0]));
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
            errors++;
          end
          if (m_axis_tuser !== want.clip) begin
            $error("clipped: expected %0b, got %0b", want.clip, m_axis_tuser);
            errors++;
          end
        end
      end
      in_fire = s_axis_tvalid && s_axis_tready;
      if (in_fire) awaited.push_back(mix_predict(sample_pair_t'(s_axis_tdata[2*SampleBits-1:0])));
    end
  end

  // feed pairs from the queue, idling between transfers at random
  always @(negedge clk) begin
    if (!s_axis_tvalid || in_fire) begin
      if (!rst && pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InBits'(pending.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // stall the result stream at random
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic queue_pair(input sample_t dest, input sample_t src);
    pending.push_back({src, dest});
  endtask

  // hold until every queued pair is sent and every result is back
  task automatic wait_drained();
    while (pending.size() != 0 || s_axis_tvalid || awaited.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgBits-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:        mix_mode   = value[ModeBits-1:0];
      REG_START_GAIN:  ramp_start = value[GainBits-1:0];
      REG_END_GAIN:    ramp_end   = value[GainBits-1:0];
      REG_RAMP_LENGTH: ramp_len   = value[RunBits-1:0];
      default: ;
    endcase
    restart_ramp();
    // let the step divider finish before anything else goes in
    repeat (2) @(negedge clk);
    while (!s_axis_tready) @(negedge clk);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return SampleMax;
      1:       return SampleMin;
      2:       return sample_t'($signed(8'($urandom())));
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic gain_t pick_gain();
    case ($urandom_range(9))
      0:       return GainMax;
      1:       return GainMin;
      2:       return GainOne;
      3:       return -GainOne;
      4:       return '0;
      5:       return gain_t'($signed(22'($urandom())));
      default: return gain_t'($urandom());
    endcase
  endfunction

  function automatic logic [RunBits-1:0] pick_length();
    case ($urandom_range(7))
      0:       return '0;
      1:       return RunBits'(1);
      2:       return '1;
      default: return RunBits'($urandom_range(40, 2));
    endcase
  endfunction

  initial begin : stimulus_p
    int                 phase;
    int                 k;
    logic [RunBits-1:0] len_val;

    mix_mode   = MODE_SCALE;
    ramp_start = GainOne;
    ramp_end   = GainOne;
    ramp_len   = RunBits'(RampLenReset);
    restart_ramp();
    gain_inc   = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (!s_axis_tready) @(negedge clk);

    // unity gain at reset: full-scale and sign-boundary samples
    queue_pair(SampleMax, SampleMax);
    queue_pair(SampleMin, SampleMin);
    queue_pair(0, -1);
    queue_pair(1, -1);
    queue_pair(-1, 1);
    wait_drained();

    // add mode, gain swinging from top to bottom of its range: clipping and run wrap
    write_reg(REG_MODE, MODE_ADD);
    write_reg(REG_START_GAIN, GainMax);
    write_reg(REG_END_GAIN, GainMin);
    write_reg(REG_RAMP_LENGTH, 3);
    queue_pair(SampleMax, SampleMax);
    queue_pair(SampleMin, SampleMin);
    queue_pair(sample_t'(1 << (SampleBits - 2)), sample_t'(1 << (SampleBits - 2)));
    queue_pair(1, -1);
    wait_drained();

    // copy mode with a zero length, taken as a one-sample run
    write_reg(REG_MODE, MODE_COPY);
    write_reg(REG_RAMP_LENGTH, 0);
    write_reg(REG_START_GAIN, -GainOne);
    write_reg(REG_END_GAIN, GainOne <<< 1);
    queue_pair(SampleMax, SampleMin);
    queue_pair(SampleMin, SampleMax);
    queue_pair(5, -3);
    wait_drained();

    // spare mode scales; a write mid run restarts the ramp
    write_reg(REG_MODE, MODE_SPARE);
    write_reg(REG_START_GAIN, 0);
    write_reg(REG_END_GAIN, GainMax);
    write_reg(REG_RAMP_LENGTH, 5);
    queue_pair(SampleMax, SampleMin);
    queue_pair(SampleMax, SampleMin);
    queue_pair(SampleMin, SampleMax);
    wait_drained();
    write_reg(REG_START_GAIN, GainOne);
    queue_pair(SampleMax, 0);
    queue_pair(SampleMin, 0);
    queue_pair(-1, 0);
    wait_drained();

    // random ramps under each idle pattern
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 63;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 63;
        end
        default: begin
          idle_pct  = 11;
          stall_pct = 11;
        end
      endcase
      len_val = (phase == 0) ? '1 : pick_length();
      write_reg(REG_MODE, ModeBits'($urandom_range(3)));
      if (phase == 0 || $urandom_range(1)) write_reg(REG_START_GAIN, pick_gain());
      if (phase == 0 || $urandom_range(1)) write_reg(REG_END_GAIN, pick_gain());
      write_reg(REG_RAMP_LENGTH, len_val);
      for (k = 0; k < 124; k++) begin
        // pause the sender halfway until every result is back
        if (k == 62) wait_drained();
        queue_pair(pick_sample(), pick_sample());
      end
      wait_drained();
    end

    // watch a few more cycles for stray results
    repeat (8) @(negedge clk);
    if (awaited.size() != 0) begin
      $error("result_sample: expected %0d more results, got none", awaited.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // bound the run
  initial begin
    #(5_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
